// ===== hw/rtl/fwpe_pkg.sv =====
// package for the queue with patience expiry
// holds the request and response structs, the action codes and the state enum
// no dependencies
package fwpe_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 16;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_TICK
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [VAL_W-1:0]   patience_in;
        logic [VAL_W-1:0]   serving_in;
    } t_req;

    typedef struct packed {
        logic                 accepted;
        logic                 entry_valid;
        logic [VAL_W-1:0]     patience_out;
        logic [VAL_W-1:0]     serving_out;
        logic [CNT_OUT_W-1:0] expired_count;
        logic [CNT_OUT_W-1:0] occupancy;
    } t_rsp;

    typedef struct packed {
        logic [VAL_W-1:0] patience;
        logic [VAL_W-1:0] serving;
    } t_entry;

endpackage

// ===== hw/rtl/fwpe_mem.sv =====
// entry storage: one write port, one read port, registered read data
// depends on fwpe_pkg
module fwpe_mem #(
    parameter int DEPTH = fwpe_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  fwpe_pkg::t_entry     i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output fwpe_pkg::t_entry     o_rdata
);
    import fwpe_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fwpe_ctrl.sv =====
// sequencer for enqueue, dequeue and the compacting tick walk
// drives the entry memory and holds head, count and the response register
// depends on fwpe_pkg
module fwpe_ctrl #(
    parameter int DEPTH = fwpe_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  fwpe_pkg::t_req       i_req,
    output logic                 o_busy,
    output logic                 o_done,
    output fwpe_pkg::t_rsp       o_rsp,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output fwpe_pkg::t_entry     o_wdata,
    output logic [AW-1:0]        o_raddr,
    input  fwpe_pkg::t_entry     i_rdata
);
    import fwpe_pkg::*;

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [CNT_OUT_W-1:0] low5(input logic [CW-1:0] c);
        logic [CW+CNT_OUT_W-1:0] ext;
        ext = {{CNT_OUT_W{1'b0}}, c};
        return ext[CNT_OUT_W-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_total, n_total;
    logic [AW-1:0]   r_rd_slot, n_rd_slot;
    logic [AW-1:0]   r_wr_slot, n_wr_slot;
    logic [CW-1:0]   r_rem, n_rem;
    logic [CW-1:0]   r_kept, n_kept;
    logic [CW-1:0]   r_expired, n_expired;
    logic            r_done, n_done;
    t_rsp            r_rsp, n_rsp;
    logic            accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_total   <= '0;
            r_rd_slot <= '0;
            r_wr_slot <= '0;
            r_rem     <= '0;
            r_kept    <= '0;
            r_expired <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_total   <= n_total;
            r_rd_slot <= n_rd_slot;
            r_wr_slot <= n_wr_slot;
            r_rem     <= n_rem;
            r_kept    <= n_kept;
            r_expired <= n_expired;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_total   = r_total;
        n_rd_slot = r_rd_slot;
        n_wr_slot = r_wr_slot;
        n_rem     = r_rem;
        n_kept    = r_kept;
        n_expired = r_expired;
        n_done    = 1'b0;
        n_rsp     = '0;
        o_we      = 1'b0;
        o_waddr   = r_wr_slot;
        o_wdata   = '0;
        o_raddr   = r_head;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.action)
                        ACT_ENQ: begin
                            n_done = 1'b1;
                            if (r_total < CW'(DEPTH)) begin
                                o_we           = 1'b1;
                                o_waddr        = slot_add(r_head, r_total[AW-1:0]);
                                o_wdata        = '{patience: i_req.patience_in,
                                                   serving:  i_req.serving_in};
                                n_total        = r_total + CW'(1);
                                n_rsp.accepted = 1'b1;
                            end
                            n_rsp.occupancy = low5(n_total);
                        end
                        ACT_DEQ: begin
                            if (r_total != '0) begin
                                n_state = S_DEQ;
                            end else begin
                                n_done          = 1'b1;
                                n_rsp.occupancy = low5(r_total);
                            end
                        end
                        ACT_TICK: begin
                            if (r_total != '0) begin
                                n_state   = S_TICK;
                                n_rd_slot = slot_add(r_head, AW'(1));
                                n_wr_slot = r_head;
                                n_rem     = r_total - CW'(1);
                                n_kept    = '0;
                                n_expired = '0;
                            end else begin
                                n_done          = 1'b1;
                                n_rsp.occupancy = low5(r_total);
                            end
                        end
                        default: begin
                            n_done          = 1'b1;
                            n_rsp.occupancy = low5(r_total);
                        end
                    endcase
                end
            end
            S_DEQ: begin
                n_state            = S_IDLE;
                n_done             = 1'b1;
                n_head             = slot_add(r_head, AW'(1));
                n_total            = r_total - CW'(1);
                n_rsp.entry_valid  = 1'b1;
                n_rsp.patience_out = i_rdata.patience;
                n_rsp.serving_out  = i_rdata.serving;
                n_rsp.occupancy    = low5(n_total);
            end
            S_TICK: begin
                if (i_rdata.patience <= VAL_W'(1)) begin
                    n_expired = r_expired + CW'(1);
                end else begin
                    o_we      = 1'b1;
                    o_waddr   = r_wr_slot;
                    o_wdata   = '{patience: i_rdata.patience - VAL_W'(1),
                                  serving:  i_rdata.serving};
                    n_wr_slot = slot_add(r_wr_slot, AW'(1));
                    n_kept    = r_kept + CW'(1);
                end
                if (r_rem != '0) begin
                    o_raddr   = r_rd_slot;
                    n_rd_slot = slot_add(r_rd_slot, AW'(1));
                    n_rem     = r_rem - CW'(1);
                end else begin
                    n_state             = S_IDLE;
                    n_done              = 1'b1;
                    n_total             = n_kept;
                    n_rsp.expired_count = low5(n_expired);
                    n_rsp.occupancy     = low5(n_kept);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(DEPTH))
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < (AW+1)'(DEPTH))
        else $error("head slot out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe while still working");

    a_tick_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TICK |-> r_kept + r_expired + r_rem < r_total)
        else $error("tick walk count mismatch");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEQ |=> r_total == $past(r_total) - CW'(1))
        else $error("dequeue did not shrink the queue");

endmodule

// ===== hw/rtl/fifo_with_patience_expiry.sv =====
// queue with patience expiry: enqueue, nop and empty dequeue answer in the cycle after the
// transfer, dequeue after its S_DEQ state, tick after walking every entry in S_TICK (one
// entry read per cycle). a new transfer is taken in the cycle the result strobe shows.
// the result strobe lasts one cycle and cannot be stalled by the receiver.
// synchronous active-low reset empties the queue; stored entries are not cleared.
// depends on fwpe_pkg, fwpe_ctrl, fwpe_mem
module fifo_with_patience_expiry #(
    parameter int DEPTH = fwpe_pkg::DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fwpe_pkg::t_req   i_req,
    output logic             o_done,
    output fwpe_pkg::t_rsp   o_rsp
);
    import fwpe_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    fwpe_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .o_we    (mem_we),
        .o_waddr (mem_waddr),
        .o_wdata (mem_wdata),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata)
    );

    fwpe_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== verif/fifo_with_patience_expiry_tb.sv =====
`timescale 1ns / 1ps
// testbench for fifo_with_patience_expiry: directed and random enqueue, dequeue, tick and nop
// transfers, each result checked field by field against a queue model kept in a scoreboard class
// depends on fwpe_pkg and fifo_with_patience_expiry
module fifo_with_patience_expiry_tb;

    import fwpe_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class fwpe_scoreboard;
        t_entry      stored[$];
        t_rsp        awaited[$];
        int unsigned mismatches;

        function void note_transfer(t_req r);
            t_rsp        rsp;
            t_entry      e;
            t_entry      kept[$];
            int unsigned gone;
            rsp  = '0;
            gone = 0;
            case (r.action)
                ACT_ENQ: begin
                    if (stored.size() < DEPTH_DEF) begin
                        e.patience = r.patience_in;
                        e.serving  = r.serving_in;
                        stored.push_back(e);
                        rsp.accepted = 1'b1;
                    end
                end
                ACT_DEQ: begin
                    if (stored.size() > 0) begin
                        e = stored.pop_front();
                        rsp.entry_valid  = 1'b1;
                        rsp.patience_out = e.patience;
                        rsp.serving_out  = e.serving;
                    end
                end
                ACT_TICK: begin
                    foreach (stored[k]) begin
                        if (stored[k].patience <= 16'd1) begin
                            gone++;
                        end else begin
                            e = stored[k];
                            e.patience = e.patience - 16'd1;
                            kept.push_back(e);
                        end
                    end
                    stored = kept;
                    rsp.expired_count = CNT_OUT_W'(gone);
                end
                default: ;
            endcase
            rsp.occupancy = CNT_OUT_W'(stored.size());
            awaited.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (want_v !== got_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want_v, got_v);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t: result with no transfer waiting, expected none got %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
            compare_field("entry_valid", 16'(want.entry_valid), 16'(got.entry_valid));
            compare_field("patience_out", want.patience_out, got.patience_out);
            compare_field("serving_out", want.serving_out, got.serving_out);
            compare_field("expired_count", 16'(want.expired_count), 16'(got.expired_count));
            compare_field("occupancy", 16'(want.occupancy), 16'(got.occupancy));
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    t_req           i_req = '0;
    logic           o_done;
    t_rsp           o_rsp;
    fwpe_scoreboard sb = new;
    int unsigned    cycles = 0;

    fifo_with_patience_expiry #(
        .DEPTH(DEPTH_DEF)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // results first, so a transfer in the strobe cycle queues behind them
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_rsp);
        end
        if (i_rst_n && start && !busy) begin
            sb.note_transfer(i_req);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("fifo_with_patience_expiry_tb failed");
            $finish;
        end
    end

    function automatic t_req make_req(t_action a, logic [15:0] p, logic [15:0] s);
        t_req r;
        r.action      = a;
        r.patience_in = p;
        r.serving_in  = s;
        return r;
    endfunction

    function automatic t_req random_req(int unsigned phase);
        int unsigned pick;
        int unsigned enq_lim;
        int unsigned deq_lim;
        int unsigned tick_lim;
        t_action     a;
        logic [15:0] p;
        case (phase)
            0: begin enq_lim = 60; deq_lim = 75; tick_lim = 92; end
            1: begin enq_lim = 45; deq_lim = 70; tick_lim = 90; end
            2: begin enq_lim = 35; deq_lim = 75; tick_lim = 90; end
            default: begin enq_lim = 50; deq_lim = 60; tick_lim = 92; end
        endcase
        pick = $urandom_range(99);
        if (pick < enq_lim) a = ACT_ENQ;
        else if (pick < deq_lim) a = ACT_DEQ;
        else if (pick < tick_lim) a = ACT_TICK;
        else a = ACT_NOP;
        // mostly short patience so ticks expire entries often
        if ($urandom_range(3) == 0) p = 16'($urandom_range(65535));
        else p = 16'($urandom_range(6));
        return make_req(a, p, 16'($urandom_range(65535)));
    endfunction

    task automatic issue(t_req r);
        start = 1'b1;
        i_req = r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic rest(int unsigned n);
        start = 1'b0;
        i_req = random_req(0);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        issue(make_req(ACT_NOP, 16'hffff, 16'hffff));
        issue(make_req(ACT_DEQ, 16'h0000, 16'h0000));
        issue(make_req(ACT_TICK, 16'h0000, 16'h0000));
        issue(make_req(ACT_ENQ, 16'h0000, 16'h0000));
        issue(make_req(ACT_ENQ, 16'h0001, 16'hffff));
        rest(3);
        issue(make_req(ACT_ENQ, 16'hffff, 16'hffff));
        issue(make_req(ACT_ENQ, 16'h0002, 16'h1234));
        issue(make_req(ACT_TICK, 16'h0000, 16'h0000));
        issue(make_req(ACT_DEQ, 16'h0000, 16'h0000));
        issue(make_req(ACT_NOP, 16'h0000, 16'h0000));
        // fill to full, last transfer is rejected
        for (int k = 0; k < DEPTH_DEF; k++) begin
            issue(make_req(ACT_ENQ, 16'hfff0 + 16'(k), 16'($urandom_range(65535))));
        end
        issue(make_req(ACT_TICK, 16'h0000, 16'h0000));
        issue(make_req(ACT_DEQ, 16'h0000, 16'h0000));

        for (int i = 0; i < 400; i++) begin
            if (i == 200) drain();
            issue(random_req(i / 100));
            if (i < 350 && !(i >= 100 && i < 150) && $urandom_range(3) == 0) begin
                rest($urandom_range(1, 5));
            end
        end

        drain();
        repeat (DEPTH_DEF + 4) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("fifo_with_patience_expiry_tb passed");
        end else begin
            $display("fifo_with_patience_expiry_tb failed");
        end
        $finish;
    end

endmodule
